[rtl/core/pcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

    localparam int SEN_W = 6;
    localparam int COL_W = 10;
    localparam int ROW_W = 9;
    localparam int HIT_W = SEN_W + COL_W + ROW_W;
    localparam int PITCH_W = 16;
    localparam int LOC_W = 17;
    localparam int LAB_W = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 21;

    typedef logic [HIT_W-1:0] t_hit;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAYOUT  = 3'd0,
        REG_SENSORS = 3'd1,
        REG_PITCH_L = 3'd2,
        REG_PITCH_S = 3'd3,
        REG_Z_OFF   = 3'd4
    } t_reg_idx;

    localparam logic signed [LAB_W-1:0] MM45 = 22'sd46080;
    localparam logic signed [LAB_W-1:0] MM30 = 22'sd30720;
    localparam logic signed [LAB_W-1:0] MM15 = 22'sd15360;
    localparam logic signed [20:0]      MM73 = 21'sd74752;
    localparam logic [LOC_W-1:0]        LOC_MAX = 17'h1FFFF;
    localparam logic signed [LAB_W-1:0] LAB_HI = 22'sd262143;
    localparam logic signed [LAB_W-1:0] LAB_LO = -22'sd262144;

    typedef struct packed {
        logic signed [LAB_W-1:0] base;
        logic                    neg;
    } t_ybase;

    function automatic logic [SEN_W-1:0] hit_sen(t_hit h);
        return h[HIT_W-1 -: SEN_W];
    endfunction

    function automatic logic [COL_W-1:0] hit_col(t_hit h);
        return h[ROW_W +: COL_W];
    endfunction

    function automatic logic [ROW_W-1:0] hit_row(t_hit h);
        return h[ROW_W-1:0];
    endfunction

    function automatic logic touching(t_hit a, t_hit b);
        logic [COL_W:0] dc;
        logic [ROW_W:0] dr;
        logic           cok;
        logic           rok;
        dc = {1'b0, hit_col(a)} - {1'b0, hit_col(b)};
        dr = {1'b0, hit_row(a)} - {1'b0, hit_row(b)};
        cok = (dc == '0) || (dc == (COL_W+1)'(1)) || (dc == '1);
        rok = (dr == '0) || (dr == (ROW_W+1)'(1)) || (dr == '1);
        return (hit_sen(a) == hit_sen(b)) && cok && rok && !((dc == '0) && (dr == '0));
    endfunction

    function automatic t_ybase ybase(logic [2:0] g);
        t_ybase y;
        case (g)
            3'd0:    y = '{base: -MM45, neg: 1'b1};
            3'd1:    y = '{base: -MM45, neg: 1'b0};
            3'd2:    y = '{base: -MM15, neg: 1'b0};
            3'd3:    y = '{base: -MM15, neg: 1'b1};
            3'd4:    y = '{base: MM15,  neg: 1'b1};
            3'd5:    y = '{base: MM15,  neg: 1'b0};
            3'd6:    y = '{base: MM45,  neg: 1'b0};
            default: y = '{base: MM45,  neg: 1'b1};
        endcase
        return y;
    endfunction

endpackage
`default_nettype wire

[rtl/core/pcc_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcc_div import pcc_pkg::*; #(
    parameter int NW = 33,
    parameter int DW = 13
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quot
);

    localparam int KW = $clog2(NW + 1);

    logic          r_busy;
    logic [KW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW:0]   w_rem_sh;
    logic          w_ge;

    always_comb begin
        w_rem_sh = {r_rem, r_q[NW-1]};
        w_ge     = (w_rem_sh >= {1'b0, i_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= KW'(NW);
            r_q    <= i_num;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? DW'(w_rem_sh - {1'b0, i_den}) : w_rem_sh[DW-1:0];
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == KW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule
`default_nettype wire

[rtl/core/pcc_lab.sv]
`timescale 1ns / 1ps
`default_nettype none
module pcc_lab import pcc_pkg::*; (
    input  wire logic              i_layout,
    input  wire logic [SEN_W-1:0]  i_sensor,
    input  wire logic [LOC_W-1:0]  i_lx,
    input  wire logic [LOC_W-1:0]  i_ly,
    input  wire logic signed [20:0] i_z_off,
    output logic signed [18:0]     o_x,
    output logic signed [18:0]     o_y,
    output logic signed [20:0]     o_z
);

    logic [4:0]              s;
    logic [2:0]              g;
    logic [4:0]              k;
    logic [1:0]              r;
    logic [4:0]              kr;
    logic [4:0]              kk;
    logic                    odd;
    logic signed [LAB_W-1:0] lx;
    logic signed [LAB_W-1:0] ly;
    logic signed [LAB_W-1:0] off;
    logic signed [LAB_W-1:0] x;
    logic signed [LAB_W-1:0] y;
    t_ybase                  yb;

    always_comb begin
        s  = 5'(i_sensor - 6'd1);
        lx = signed'({5'd0, i_lx});
        ly = signed'({5'd0, i_ly});

        g = 3'd0;
        if (s >= 5'd3)  g = 3'd1;
        if (s >= 5'd6)  g = 3'd2;
        if (s >= 5'd9)  g = 3'd3;
        if (s >= 5'd12) g = 3'd4;
        if (s >= 5'd15) g = 3'd5;
        if (s >= 5'd18) g = 3'd6;
        k = s - 5'({2'b0, g} << 1) - 5'({2'b0, g});
        if (s >= 5'd21) begin
            g = 3'd7;
            k = s - 5'd21;
        end

        r = 2'd0;
        if (s >= 5'd3) r = 2'd1;
        if (s >= 5'd6) r = 2'd2;
        if (s >= 5'd9) r = 2'd3;
        kr = s - 5'({3'b0, r} << 1) - 5'({3'b0, r});

        kk  = i_layout ? kr : k;
        odd = i_layout ? r[0] : g[0];
        off = signed'(22'(kk) * 22'd30720);

        if (odd) x = -MM45 + off + lx;
        else     x = MM45 - off - lx;

        yb = ybase(g);
        if (i_layout) begin
            y   = odd ? ly : -ly;
            o_z = r[1] ? MM73 : 21'sd0;
        end else begin
            y   = yb.neg ? (yb.base - ly) : (yb.base + ly);
            o_z = i_z_off;
        end

        if (x > LAB_HI)      o_x = 19'sd262143;
        else if (x < LAB_LO) o_x = -19'sd262144;
        else                 o_x = x[18:0];
        if (y > LAB_HI)      o_y = 19'sd262143;
        else if (y < LAB_LO) o_y = -19'sd262144;
        else                 o_y = y[18:0];
    end

endmodule
`default_nettype wire

[rtl/core/pixel_cluster_centroid_finder_unit.sv]
// channel | dir | handshake                 | payload
// hit in  | in  | i_in_valid / o_in_ready   | i_sensor_id, i_pixel_column, i_pixel_row, i_last_hit
// cluster | out | o_out_valid / i_out_ready | o_cluster_*, o_local_*, o_lab_*, o_last_cluster,
//         |     |                           | o_hits_dropped
// config  | in  | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// Hits load at one beat per cycle. After the last hit the hit store is walked by a
// flood fill: each cluster member scans all n stored hits through the single read
// port. Emission scans sensor x cluster pairs; each emitted cluster adds two serial
// divisions. o_in_ready is low from the last hit until the unit is back in S_LOAD
// via S_FIN: after the final cluster beat is taken, or from S_EINIT if none counted.
// Reset is synchronous, active low; memories are not reset.
`timescale 1ns / 1ps
`default_nettype none
module pixel_cluster_centroid_finder_unit import pcc_pkg::*; #(
    parameter int MAX_HITS    = 64,
    parameter int MAX_SENSORS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [SEN_W-1:0]      i_sensor_id,
    input  wire logic [COL_W-1:0]      i_pixel_column,
    input  wire logic [ROW_W-1:0]      i_pixel_row,
    input  wire logic                  i_last_hit,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [5:0]                 o_cluster_sensor,
    output logic [6:0]                 o_cluster_size,
    output logic signed [17:0]         o_local_x,
    output logic signed [17:0]         o_local_y,
    output logic signed [18:0]         o_lab_x,
    output logic signed [18:0]         o_lab_y,
    output logic signed [20:0]         o_lab_z,
    output logic                       o_last_cluster,
    output logic                       o_hits_dropped,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW   = $clog2(MAX_HITS);
    localparam int CW   = $clog2(MAX_HITS + 1);
    localparam int SUMW = COL_W + AW;
    localparam int NW   = SUMW + PITCH_W + 1;
    localparam int DW   = CW + 6;

    typedef enum logic [16:0] {
        S_LOAD  = 17'd1 << 0,
        S_OUTER = 17'd1 << 1,
        S_SEED  = 17'd1 << 2,
        S_SCAN  = 17'd1 << 3,
        S_DRAIN = 17'd1 << 4,
        S_NEXT  = 17'd1 << 5,
        S_POPW  = 17'd1 << 6,
        S_LOADP = 17'd1 << 7,
        S_EINIT = 17'd1 << 8,
        S_ERD   = 17'd1 << 9,
        S_ECHK  = 17'd1 << 10,
        S_MUL   = 17'd1 << 11,
        S_DST   = 17'd1 << 12,
        S_DWT   = 17'd1 << 13,
        S_LAB   = 17'd1 << 14,
        S_OUT   = 17'd1 << 15,
        S_FIN   = 17'd1 << 16
    } t_state;

    typedef struct packed {
        logic [SEN_W-1:0] sen;
        logic [SUMW-1:0]  col;
        logic [SUMW-1:0]  row;
        logic [CW-1:0]    cnt;
    } t_clus;

    t_state                 r_state;
    logic                   r_layout;
    logic [5:0]             r_sens_use;
    logic [PITCH_W-1:0]     r_pitch_l;
    logic [PITCH_W-1:0]     r_pitch_s;
    logic signed [20:0]     r_z_off;

    logic [CW-1:0]          r_hit_count;
    logic                   r_overflow;
    logic [MAX_HITS-1:0]    r_done;
    logic [CW-1:0]          r_i;
    logic [CW-1:0]          r_j;
    logic [CW-1:0]          r_sp;
    logic [CW-1:0]          r_nlab;
    logic [CW-1:0]          r_total;
    logic [CW-1:0]          r_emitted;
    logic [CW-1:0]          r_l;
    logic [5:0]             r_s;
    logic                   r_ev_v;
    logic [AW-1:0]          r_ev_j;
    t_hit                   r_p_hit;
    logic [SUMW-1:0]        r_acc_col;
    logic [SUMW-1:0]        r_acc_row;
    logic [CW-1:0]          r_acc_cnt;
    logic [SEN_W-1:0]       r_acc_sen;
    t_clus                  r_e;
    logic                   r_axis;
    logic [NW-1:0]          r_num;
    logic [DW-1:0]          r_den;
    logic [LOC_W-1:0]       r_lx;
    logic [LOC_W-1:0]       r_ly;

    logic                   r_o_valid;
    logic [5:0]             r_o_sen;
    logic [6:0]             r_o_size;
    logic [LOC_W-1:0]       r_o_lx;
    logic [LOC_W-1:0]       r_o_ly;
    logic signed [18:0]     r_o_x;
    logic signed [18:0]     r_o_y;
    logic signed [20:0]     r_o_z;
    logic                   r_o_last;
    logic                   r_o_drop;

    t_hit                   m_hit [MAX_HITS];
    logic [AW-1:0]          m_stk [MAX_HITS];
    t_clus                  m_clus [MAX_HITS];
    t_hit                   r_hit_rd;
    logic [AW-1:0]          r_stk_rd;
    t_clus                  r_clus_rd;

    logic                   w_accept;
    logic                   w_store;
    logic [AW-1:0]          w_hit_ra;
    logic                   w_touch;
    logic [CW-1:0]          w_sp_m1;
    logic [5:0]             w_ns;
    logic                   w_emit_ok;
    logic                   w_close;
    logic                   w_div_busy;
    logic [NW-1:0]          w_quot;
    logic [LOC_W-1:0]       w_loc;
    logic [SUMW-1:0]        w_sum;
    logic [PITCH_W-1:0]     w_pitch;
    logic signed [18:0]     w_lab_x;
    logic signed [18:0]     w_lab_y;
    logic signed [20:0]     w_lab_z;
    logic                   w_l_wrap;

    assign o_in_ready = (r_state == S_LOAD);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_store    = w_accept && (r_hit_count < CW'(MAX_HITS));
    assign w_sp_m1    = r_sp - 1'b1;
    assign w_ns       = (r_sens_use > 6'(MAX_SENSORS)) ? 6'(MAX_SENSORS) : r_sens_use;
    assign w_emit_ok  = (r_acc_sen >= 6'd1) && (r_acc_sen <= w_ns);
    assign w_close    = (r_state == S_NEXT) && (r_sp == '0);
    assign w_touch    = r_ev_v && !r_done[r_ev_j] && touching(r_p_hit, r_hit_rd);
    assign w_loc      = (|w_quot[NW-1:LOC_W]) ? LOC_MAX : w_quot[LOC_W-1:0];
    assign w_sum      = r_axis ? r_e.row : r_e.col;
    assign w_pitch    = r_axis ? r_pitch_s : r_pitch_l;
    assign w_l_wrap   = (CW'(r_l + 1'b1) == r_nlab);

    always_comb begin
        w_hit_ra = r_i[AW-1:0];
        if (r_state == S_SCAN) w_hit_ra = r_j[AW-1:0];
        if (r_state == S_POPW) w_hit_ra = r_stk_rd;
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            m_hit[r_hit_count[AW-1:0]] <= {i_sensor_id, i_pixel_column, i_pixel_row};
        end
        r_hit_rd <= m_hit[w_hit_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_touch) begin
            m_stk[r_sp[AW-1:0]] <= r_ev_j;
        end
        r_stk_rd <= m_stk[w_sp_m1[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            m_clus[r_nlab[AW-1:0]] <= '{sen: r_acc_sen, col: r_acc_col,
                                        row: r_acc_row, cnt: r_acc_cnt};
        end
        r_clus_rd <= m_clus[r_l[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout   <= 1'b0;
            r_sens_use <= 6'd24;
            r_pitch_l  <= 16'd1916;
            r_pitch_s  <= 16'd1762;
            r_z_off    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_LAYOUT:  r_layout   <= i_cfg_data[0];
                REG_SENSORS: r_sens_use <= i_cfg_data[5:0];
                REG_PITCH_L: r_pitch_l  <= i_cfg_data[PITCH_W-1:0];
                REG_PITCH_S: r_pitch_s  <= i_cfg_data[PITCH_W-1:0];
                REG_Z_OFF:   r_z_off    <= signed'(i_cfg_data[20:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_v <= 1'b0;
        end else begin
            r_ev_v <= (r_state == S_SCAN);
        end
        r_ev_j <= r_j[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_hit_count <= '0;
            r_overflow  <= 1'b0;
            r_done      <= '0;
            r_sp        <= '0;
            r_o_valid   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_nlab      <= '0;
            r_total     <= '0;
            r_emitted   <= '0;
            r_l         <= '0;
            r_s         <= '0;
            r_axis      <= 1'b0;
        end else begin
            if (w_touch) begin
                r_done[r_ev_j] <= 1'b1;
                r_sp      <= r_sp + 1'b1;
                r_acc_col <= r_acc_col + SUMW'(hit_col(r_hit_rd));
                r_acc_row <= r_acc_row + SUMW'(hit_row(r_hit_rd));
                r_acc_cnt <= r_acc_cnt + 1'b1;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (w_store) r_hit_count <= r_hit_count + 1'b1;
                        else         r_overflow  <= 1'b1;
                        if (i_last_hit) begin
                            r_state <= S_OUTER;
                            r_i     <= '0;
                            r_nlab  <= '0;
                            r_sp    <= '0;
                            r_total <= '0;
                            r_done  <= '0;
                        end
                    end
                end
                S_OUTER: begin
                    if (r_i == r_hit_count) begin
                        r_state <= S_EINIT;
                    end else if (r_done[r_i[AW-1:0]]) begin
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_done[r_i[AW-1:0]] <= 1'b1;
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    r_p_hit   <= r_hit_rd;
                    r_acc_col <= SUMW'(hit_col(r_hit_rd));
                    r_acc_row <= SUMW'(hit_row(r_hit_rd));
                    r_acc_cnt <= CW'(1);
                    r_acc_sen <= hit_sen(r_hit_rd);
                    r_j       <= '0;
                    r_state   <= S_SCAN;
                end
                S_SCAN: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == CW'(r_hit_count - 1'b1)) r_state <= S_DRAIN;
                end
                S_DRAIN: r_state <= S_NEXT;
                S_NEXT: begin
                    if (r_sp == '0) begin
                        r_nlab  <= r_nlab + 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_total <= r_total + CW'(w_emit_ok);
                        r_state <= S_OUTER;
                    end else begin
                        r_sp    <= w_sp_m1;
                        r_state <= S_POPW;
                    end
                end
                S_POPW: r_state <= S_LOADP;
                S_LOADP: begin
                    r_p_hit <= r_hit_rd;
                    r_j     <= '0;
                    r_state <= S_SCAN;
                end
                S_EINIT: begin
                    r_s       <= 6'd1;
                    r_l       <= '0;
                    r_emitted <= '0;
                    r_state   <= (r_total == '0) ? S_FIN : S_ERD;
                end
                S_ERD: r_state <= S_ECHK;
                S_ECHK: begin
                    if (r_clus_rd.sen == r_s) begin
                        r_e     <= r_clus_rd;
                        r_axis  <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        if (w_l_wrap) begin
                            r_l <= '0;
                            r_s <= r_s + 1'b1;
                        end else begin
                            r_l <= r_l + 1'b1;
                        end
                        r_state <= S_ERD;
                    end
                end
                S_MUL: begin
                    r_num   <= NW'(w_sum) * NW'(w_pitch) + NW'({r_e.cnt, 5'b0});
                    r_den   <= {r_e.cnt, 6'b0};
                    r_state <= S_DST;
                end
                S_DST: r_state <= S_DWT;
                S_DWT: begin
                    if (!w_div_busy) begin
                        if (!r_axis) begin
                            r_lx    <= w_loc;
                            r_axis  <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_ly    <= w_loc;
                            r_state <= S_LAB;
                        end
                    end
                end
                S_LAB: begin
                    r_o_valid <= 1'b1;
                    r_o_sen   <= r_e.sen;
                    r_o_size  <= 7'(r_e.cnt);
                    r_o_lx    <= r_lx;
                    r_o_ly    <= r_ly;
                    r_o_x     <= w_lab_x;
                    r_o_y     <= w_lab_y;
                    r_o_z     <= w_lab_z;
                    r_o_last  <= (r_emitted == CW'(r_total - 1'b1));
                    r_o_drop  <= r_overflow;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_o_valid <= 1'b0;
                        r_emitted <= r_emitted + 1'b1;
                        if (r_o_last) begin
                            r_state <= S_FIN;
                        end else begin
                            if (w_l_wrap) begin
                                r_l <= '0;
                                r_s <= r_s + 1'b1;
                            end else begin
                                r_l <= r_l + 1'b1;
                            end
                            r_state <= S_ERD;
                        end
                    end
                end
                S_FIN: begin
                    r_hit_count <= '0;
                    r_overflow  <= 1'b0;
                    r_state     <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    pcc_div #(
        .NW(NW),
        .DW(DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DST),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    pcc_lab u_lab (
        .i_layout (r_layout),
        .i_sensor (r_e.sen),
        .i_lx     (r_lx),
        .i_ly     (r_ly),
        .i_z_off  (r_z_off),
        .o_x      (w_lab_x),
        .o_y      (w_lab_y),
        .o_z      (w_lab_z)
    );

    assign o_out_valid      = r_o_valid;
    assign o_cluster_sensor = r_o_sen;
    assign o_cluster_size   = r_o_size;
    assign o_local_x        = signed'({1'b0, r_o_lx});
    assign o_local_y        = signed'({1'b0, r_o_ly});
    assign o_lab_x          = r_o_x;
    assign o_lab_y          = r_o_y;
    assign o_lab_z          = r_o_z;
    assign o_last_cluster   = r_o_last;
    assign o_hits_dropped   = r_o_drop;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= r_hit_count)
        else $error("stack deeper than stored hits");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !r_o_valid)
        else $error("accepting hits with result pending");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DWT))
        else $error("divider busy outside wait state");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_emitted < r_total))
        else $error("more clusters emitted than counted");

endmodule
`default_nettype wire
